FILE: design/mbd_pkg.sv
`timescale 1ns / 1ps

package mbd_pkg;

  localparam int KEY_ROW_COUNT_DEF = 64;

  // operation codes
  localparam logic [2:0] OP_MEM_READ  = 3'd0;
  localparam logic [2:0] OP_MEM_WRITE = 3'd1;
  localparam logic [2:0] OP_IO_IN     = 3'd2;
  localparam logic [2:0] OP_IO_OUT    = 3'd3;
  localparam logic [2:0] OP_KEY_WRITE = 3'd4;
  localparam logic [2:0] OP_ROM_LOAD  = 3'd5;

  // video access codes
  localparam logic [1:0] VA_NONE = 2'd0;
  localparam logic [1:0] VA_CHAR = 2'd1;
  localparam logic [1:0] VA_PAGE = 2'd2;
  localparam logic [1:0] VA_PORT = 2'd3;

  // port numbers
  localparam logic [2:0] PORT_CTRL = 3'd1;
  localparam logic [2:0] PORT_KEYS = 3'd3;

  localparam logic [7:0] OPEN_BUS  = 8'hFF;
  localparam int         GROUP_BIT = 1;

  // layout of the shared store
  localparam int LOW_OFF   = 0;
  localparam int ROM_OFF   = 32'h0_8000;
  localparam int HIGH_OFF  = 32'h1_0000;
  localparam int HIGH_SIZE = 13312;
  localparam int KEY_OFF   = HIGH_OFF + HIGH_SIZE;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  video_access;
    logic        video_write;
    logic [10:0] video_offset;
    logic [7:0]  video_data;
    logic [2:0]  video_port;
    logic [15:0] video_bus_address;
  } res_t;

endpackage

FILE: design/mbd_ram.sv
`timescale 1ns / 1ps

module mbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/machine_bus_decoder.sv
`timescale 1ns / 1ps
// A word accepted on the input goes into the stage-1 register and then into the output register.
// Throughput: one word per cycle while out_stall is low; each word makes at most one access to the single-port
// store that holds low RAM, high RAM, ROM and keyboard rows.
// Reset (rst_n low, synchronous): pipeline empty, boot mirror on, video group off,
// rom_extended 0, all keyboard rows read as zero; RAM and ROM contents undefined.
module machine_bus_decoder #(
  parameter int KEY_ROW_COUNT = mbd_pkg::KEY_ROW_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [2:0]  in_port,
  input  logic [7:0]  in_data,
  input  logic [5:0]  in_key_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_video_access,
  output logic        out_video_write,
  output logic [10:0] out_video_offset,
  output logic [7:0]  out_video_data,
  output logic [2:0]  out_video_port,
  output logic [15:0] out_video_bus_address
);
  import mbd_pkg::*;

  localparam int RAM_DEPTH = KEY_OFF + KEY_ROW_COUNT;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int KRW       = (KEY_ROW_COUNT > 1) ? $clog2(KEY_ROW_COUNT) : 1;

  logic                     rom_ext_r;
  logic                     mirror_r, mirror_nxt;
  logic                     group_r, group_nxt;
  logic [KEY_ROW_COUNT-1:0] key_vld_r, key_vld_nxt;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_use_ram_r, s1_use_ram_nxt;
  res_t s1_res_r, s1_res_nxt;
  logic out_valid_r;
  res_t out_res_r, out_res_nxt;

  logic              s1_adv, in_acc;
  logic              ram_en, ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_rdata;

  logic [15:0] a;
  logic        in_rom, in_mirror, in_char, in_page, in_high;
  logic        row_ok, krow_ok;
  logic [5:0]  krow;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign a         = in_address;
  assign in_rom    = (a[15:14] == 2'b10);
  assign in_mirror = mirror_r && (a[15:14] == 2'b00);
  assign in_char   = (a[15:10] == 6'b111101);
  assign in_page   = (a[15:11] == 5'b11111);
  assign in_high   = (a[15:14] == 2'b11);
  assign row_ok    = (32'(in_key_row) < KEY_ROW_COUNT);
  assign krow      = a[5:0];
  assign krow_ok   = (32'(krow) < KEY_ROW_COUNT);

  always_comb begin
    s1_res_nxt     = '0;
    s1_use_ram_nxt = 1'b0;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = '0;
    mirror_nxt     = mirror_r;
    group_nxt      = group_r;
    key_vld_nxt    = key_vld_r;
    unique case (in_operation)
      OP_MEM_READ: begin
        if (in_rom || in_mirror) begin
          ram_en         = 1'b1;
          ram_addr       = RAM_AW'(ROM_OFF + 32'(a[14:0]));
          s1_use_ram_nxt = 1'b1;
        end else if (in_char) begin
          s1_res_nxt.video_access = VA_CHAR;
          s1_res_nxt.video_offset = {1'b0, a[9:0]};
        end else if (in_page) begin
          s1_res_nxt.video_access = VA_PAGE;
          s1_res_nxt.video_offset = a[10:0];
        end else if (in_high) begin
          ram_en         = 1'b1;
          ram_addr       = rom_ext_r ? RAM_AW'(ROM_OFF + 32'(a[14:0]))
                                     : RAM_AW'(HIGH_OFF + 32'(a[13:0]));
          s1_use_ram_nxt = 1'b1;
        end else begin
          ram_en         = 1'b1;
          ram_addr       = RAM_AW'(LOW_OFF + 32'(a[14:0]));
          s1_use_ram_nxt = 1'b1;
        end
      end
      OP_MEM_WRITE: begin
        if (in_rom || in_mirror) begin
          ram_en = 1'b0;
        end else if (in_char || in_page) begin
          s1_res_nxt.video_access = in_char ? VA_CHAR : VA_PAGE;
          s1_res_nxt.video_write  = 1'b1;
          s1_res_nxt.video_offset = in_char ? {1'b0, a[9:0]} : a[10:0];
          s1_res_nxt.video_data   = in_data;
        end else if (in_high) begin
          ram_en   = !rom_ext_r;
          ram_we   = 1'b1;
          ram_addr = RAM_AW'(HIGH_OFF + 32'(a[13:0]));
        end else begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = RAM_AW'(LOW_OFF + 32'(a[14:0]));
        end
      end
      OP_IO_IN: begin
        if (!group_r && in_port == PORT_KEYS) begin
          if (krow_ok && key_vld_r[krow[KRW-1:0]]) begin
            ram_en         = 1'b1;
            ram_addr       = RAM_AW'(KEY_OFF + 32'(krow));
            s1_use_ram_nxt = 1'b1;
          end
        end else begin
          s1_res_nxt.read_data = OPEN_BUS;
        end
      end
      OP_IO_OUT: begin
        if (in_port == PORT_CTRL) begin
          if (in_acc) begin
            group_nxt  = in_data[GROUP_BIT];
            mirror_nxt = 1'b0;
          end
        end else if (group_r && in_port >= PORT_KEYS) begin
          s1_res_nxt.video_access      = VA_PORT;
          s1_res_nxt.video_data        = in_data;
          s1_res_nxt.video_port        = in_port;
          s1_res_nxt.video_bus_address = a;
        end
      end
      OP_KEY_WRITE: begin
        if (row_ok) begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = RAM_AW'(KEY_OFF + 32'(in_key_row));
          if (in_acc) begin
            key_vld_nxt[in_key_row[KRW-1:0]] = 1'b1;
          end
        end
      end
      OP_ROM_LOAD: begin
        ram_en   = !a[15];
        ram_we   = 1'b1;
        ram_addr = RAM_AW'(ROM_OFF + 32'(a[14:0]));
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
    ram_en = ram_en && in_acc;
  end

  assign s1_valid_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  mbd_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_res_nxt = s1_res_r;
    if (s1_use_ram_r) begin
      out_res_nxt.read_data = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_ext_r   <= 1'b0;
      mirror_r    <= 1'b1;
      group_r     <= 1'b0;
      key_vld_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rom_ext_r <= cfg_wr_data;
      end
      mirror_r   <= mirror_nxt;
      group_r    <= group_nxt;
      key_vld_r  <= key_vld_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // hold stage payload while stalled; advance into the output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r     <= s1_res_nxt;
      s1_use_ram_r <= s1_use_ram_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_read_data         = out_res_r.read_data;
  assign out_video_access      = out_res_r.video_access;
  assign out_video_write       = out_res_r.video_write;
  assign out_video_offset      = out_res_r.video_offset;
  assign out_video_data        = out_res_r.video_data;
  assign out_video_port        = out_res_r.video_port;
  assign out_video_bus_address = out_res_r.video_bus_address;

endmodule

FILE: design/mbd_chk.sv
`timescale 1ns / 1ps

module mbd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [7:0]  out_read_data,
  input logic [1:0]  out_video_access,
  input logic        out_video_write,
  input logic [10:0] out_video_offset,
  input logic [7:0]  out_video_data,
  input logic [2:0]  out_video_port,
  input logic [15:0] out_video_bus_address
);
  import mbd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_no_video_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_video_access == VA_NONE |->
      !out_video_write && out_video_offset == '0 && out_video_data == '0)
    else $error("video fields set without video access");

  a_port_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_video_access != VA_PORT |->
      out_video_port == '0 && out_video_bus_address == '0)
    else $error("port fields set without port out");

  a_fwd_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_video_access != VA_NONE |-> out_read_data == '0)
    else $error("read data set on forwarded access");

  a_port_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_video_access == VA_PORT |->
      out_video_port >= PORT_KEYS && !out_video_write)
    else $error("bad video port out");

endmodule

bind machine_bus_decoder mbd_chk u_mbd_chk (.*);

FILE: sim/machine_bus_decoder_tb.sv
`timescale 1ns / 1ps

import mbd_pkg::*;

typedef struct packed {
  logic [2:0]  operation;
  logic [15:0] address;
  logic [2:0]  port;
  logic [7:0]  data;
  logic [5:0]  key_row;
} bus_word_t;

class bus_shadow;
  localparam logic [15:0] ROM_BASE   = 16'h8000;
  localparam logic [15:0] HIGH_BASE  = 16'hC000;
  localparam logic [15:0] MIRROR_END = 16'h4000;
  localparam logic [15:0] CHAR_BASE  = 16'hF400;
  localparam logic [15:0] PAGE_BASE  = 16'hF800;
  localparam logic [2:0]  VIDEO_PORT_LO = 3'd3;

  byte unsigned low_mem[32768];
  bit           low_known[32768];
  byte unsigned high_mem[HIGH_SIZE];
  bit           high_known[HIGH_SIZE];
  byte unsigned rom_mem[32768];
  bit           rom_known[32768];
  byte unsigned key_mem[KEY_ROW_COUNT_DEF];
  bit           mirror_on;
  bit           video_group;
  bit           rom_ext;
  res_t         pending_replies[$];
  int           mismatch_count;

  function new();
    mirror_on = 1'b1;
    video_group = 1'b0;
    rom_ext = 1'b0;
    mismatch_count = 0;
    foreach (key_mem[i]) key_mem[i] = 8'h00;
  endfunction

  function bit can_read(logic [15:0] a);
    int addr;
    addr = a;
    if (addr >= ROM_BASE && addr < HIGH_BASE) return rom_known[addr - ROM_BASE];
    if (mirror_on && addr < MIRROR_END) return rom_known[addr];
    if (addr >= CHAR_BASE) return 1'b1;
    if (addr >= HIGH_BASE) begin
      if (rom_ext) return rom_known[addr - ROM_BASE];
      return high_known[addr - HIGH_BASE];
    end
    return low_known[addr];
  endfunction

  function void note_access(bus_word_t w);
    res_t r;
    int addr;
    r = '0;
    addr = w.address;
    case (w.operation)
      OP_MEM_READ: begin
        if (addr >= ROM_BASE && addr < HIGH_BASE) begin
          r.read_data = rom_mem[addr - ROM_BASE];
        end else if (mirror_on && addr < MIRROR_END) begin
          r.read_data = rom_mem[addr];
        end else if (addr >= PAGE_BASE) begin
          r.video_access = VA_PAGE;
          r.video_offset = 11'(addr - PAGE_BASE);
        end else if (addr >= CHAR_BASE) begin
          r.video_access = VA_CHAR;
          r.video_offset = 11'(addr - CHAR_BASE);
        end else if (addr >= HIGH_BASE) begin
          if (rom_ext) r.read_data = rom_mem[addr - ROM_BASE];
          else r.read_data = high_mem[addr - HIGH_BASE];
        end else begin
          r.read_data = low_mem[addr];
        end
      end
      OP_MEM_WRITE: begin
        if (!(addr >= ROM_BASE && addr < HIGH_BASE) && !(mirror_on && addr < MIRROR_END)) begin
          if (addr >= PAGE_BASE) begin
            r.video_access = VA_PAGE;
            r.video_write = 1'b1;
            r.video_offset = 11'(addr - PAGE_BASE);
            r.video_data = w.data;
          end else if (addr >= CHAR_BASE) begin
            r.video_access = VA_CHAR;
            r.video_write = 1'b1;
            r.video_offset = 11'(addr - CHAR_BASE);
            r.video_data = w.data;
          end else if (addr >= HIGH_BASE) begin
            if (!rom_ext) begin
              high_mem[addr - HIGH_BASE] = w.data;
              high_known[addr - HIGH_BASE] = 1'b1;
            end
          end else begin
            low_mem[addr] = w.data;
            low_known[addr] = 1'b1;
          end
        end
      end
      OP_IO_IN: begin
        if (!video_group && w.port == PORT_KEYS) r.read_data = key_mem[w.address[5:0]];
        else r.read_data = OPEN_BUS;
      end
      OP_IO_OUT: begin
        if (w.port == PORT_CTRL) begin
          video_group = w.data[GROUP_BIT];
          mirror_on = 1'b0;
        end else if (video_group && w.port >= VIDEO_PORT_LO) begin
          r.video_access = VA_PORT;
          r.video_data = w.data;
          r.video_port = w.port;
          r.video_bus_address = w.address;
        end
      end
      OP_KEY_WRITE: begin
        key_mem[w.key_row] = w.data;
      end
      OP_ROM_LOAD: begin
        if (!w.address[15]) begin
          rom_mem[w.address[14:0]] = w.data;
          rom_known[w.address[14:0]] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    pending_replies.push_back(r);
  endfunction

  task flag_mismatch(string what, logic [15:0] got_v, logic [15:0] want_v);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got_v, want_v);
    mismatch_count++;
  endtask

  task check_reply(res_t got);
    res_t want;
    if (pending_replies.size() == 0) begin
      flag_mismatch("word with nothing pending", got.video_bus_address, 16'h0000);
    end else begin
      want = pending_replies.pop_front();
      if (got.read_data !== want.read_data)
        flag_mismatch("read_data", 16'(got.read_data), 16'(want.read_data));
      if (got.video_access !== want.video_access)
        flag_mismatch("video_access", 16'(got.video_access), 16'(want.video_access));
      if (got.video_write !== want.video_write)
        flag_mismatch("video_write", 16'(got.video_write), 16'(want.video_write));
      if (got.video_offset !== want.video_offset)
        flag_mismatch("video_offset", 16'(got.video_offset), 16'(want.video_offset));
      if (got.video_data !== want.video_data)
        flag_mismatch("video_data", 16'(got.video_data), 16'(want.video_data));
      if (got.video_port !== want.video_port)
        flag_mismatch("video_port", 16'(got.video_port), 16'(want.video_port));
      if (got.video_bus_address !== want.video_bus_address)
        flag_mismatch("video_bus_address", got.video_bus_address, want.video_bus_address);
    end
  endtask
endclass

module machine_bus_decoder_tb;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [15:0] VIDEO_BASE = 16'hF400;
  localparam int HOLD_LEN = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = '0;
  logic [15:0] in_address = '0;
  logic [2:0]  in_port = '0;
  logic [7:0]  in_data = '0;
  logic [5:0]  in_key_row = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic [1:0]  out_video_access;
  logic        out_video_write;
  logic [10:0] out_video_offset;
  logic [7:0]  out_video_data;
  logic [2:0]  out_video_port;
  logic [15:0] out_video_bus_address;

  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;

  bus_shadow shadow = new();

  machine_bus_decoder DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_address(in_address),
    .in_port(in_port),
    .in_data(in_data),
    .in_key_row(in_key_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_data(out_read_data),
    .out_video_access(out_video_access),
    .out_video_write(out_video_write),
    .out_video_offset(out_video_offset),
    .out_video_data(out_video_data),
    .out_video_port(out_video_port),
    .out_video_bus_address(out_video_bus_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      shadow.check_reply({out_read_data, out_video_access, out_video_write, out_video_offset,
                          out_video_data, out_video_port, out_video_bus_address});
  end

  function automatic bus_word_t mk(logic [2:0] op, logic [15:0] a, logic [2:0] p,
                                   logic [7:0] d, logic [5:0] r);
    return bus_word_t'({op, a, p, d, r});
  endfunction

  function automatic logic [15:0] pick_address();
    logic [15:0] off;
    off = 16'($urandom_range(0, 63));
    case ($urandom_range(0, 13))
      0, 1, 2: return 16'($urandom);
      3: return 16'h0000 + off;
      4: return 16'h2000 + off;
      5: return 16'h3FC0 + off;
      6: return 16'h4000 + off;
      7: return 16'h7FC0 + off;
      8: return 16'h8000 + off;
      9: return 16'hBFC0 + off;
      10: return 16'hC000 + off;
      11: return 16'hF3C0 + off;
      12: return 16'hF7C0 + off;
      default: return 16'hFFC0 + off;
    endcase
  endfunction

  // stay on written entries; video space is always safe to read
  function automatic logic [15:0] readable_address();
    logic [15:0] a;
    for (int i = 0; i < 16; i++) begin
      a = pick_address();
      if (shadow.can_read(a)) return a;
    end
    return VIDEO_BASE + 16'($urandom_range(0, 16'h0BFF));
  endfunction

  function automatic bus_word_t random_word();
    bus_word_t w;
    int pick;
    w.operation = OP_SPARE_A;
    w.address = 16'($urandom);
    w.port = 3'($urandom);
    w.data = 8'($urandom);
    w.key_row = 6'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      w.operation = OP_MEM_READ;
      w.address = readable_address();
    end else if (pick < 53) begin
      w.operation = OP_MEM_WRITE;
      w.address = pick_address();
    end else if (pick < 63) begin
      w.operation = OP_IO_IN;
      if ($urandom_range(0, 1) == 0) w.port = PORT_KEYS;
    end else if (pick < 75) begin
      w.operation = OP_IO_OUT;
      if ($urandom_range(0, 4) == 0) w.port = PORT_CTRL;
    end else if (pick < 83) begin
      w.operation = OP_KEY_WRITE;
    end else if (pick < 95) begin
      w.operation = OP_ROM_LOAD;
      w.address = pick_address();
      if ($urandom_range(0, 7) != 0) w.address[15] = 1'b0;
    end else if ($urandom_range(0, 1) == 0) begin
      w.operation = OP_SPARE_B;
    end
    return w;
  endfunction

  task automatic send_word(input bus_word_t w);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= w.operation;
    in_address <= w.address;
    in_port <= w.port;
    in_data <= w.data;
    in_key_row <= w.key_row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_access(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_rom_extended(input logic v);
    drain();
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    shadow.rom_ext = v;
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_rom_extended(1'b0);

    send_word(mk(OP_ROM_LOAD, 16'h0000, 3'd0, 8'hA5, 6'd0));
    send_word(mk(OP_ROM_LOAD, 16'h3FFF, 3'd0, 8'h5A, 6'd0));
    send_word(mk(OP_ROM_LOAD, 16'hFFFF, 3'd7, 8'hFF, 6'd63));
    send_word(mk(OP_MEM_READ, 16'h0000, 3'd0, 8'h00, 6'd0));
    send_word(mk(OP_MEM_WRITE, 16'h3FFF, 3'd0, 8'h00, 6'd0));
    send_word(mk(OP_MEM_READ, 16'hBFFF, 3'd0, 8'h00, 6'd0));
    send_word(mk(OP_MEM_WRITE, 16'h8000, 3'd0, 8'hFF, 6'd0));
    send_word(mk(OP_MEM_READ, 16'h8000, 3'd0, 8'h00, 6'd0));
    send_word(mk(OP_MEM_WRITE, 16'hF400, 3'd0, 8'h00, 6'd0));
    send_word(mk(OP_MEM_WRITE, 16'hFFFF, 3'd0, 8'hFF, 6'd0));
    send_word(mk(OP_MEM_READ, 16'hF7FF, 3'd0, 8'h00, 6'd0));
    send_word(mk(OP_MEM_READ, 16'hF800, 3'd0, 8'h00, 6'd0));
    send_word(mk(OP_MEM_WRITE, 16'hF3FF, 3'd0, 8'hC3, 6'd0));
    send_word(mk(OP_MEM_READ, 16'hF3FF, 3'd0, 8'h00, 6'd0));
    send_word(mk(OP_KEY_WRITE, 16'h0000, 3'd0, 8'h81, 6'd63));
    send_word(mk(OP_IO_IN, 16'hFFFF, PORT_KEYS, 8'h00, 6'd0));
    send_word(mk(OP_IO_IN, 16'h0000, 3'd0, 8'h00, 6'd0));
    send_word(mk(OP_IO_OUT, 16'hFFFF, 3'd7, 8'hFF, 6'd0));
    send_word(mk(OP_IO_OUT, 16'h0000, PORT_CTRL, 8'h02, 6'd0));
    send_word(mk(OP_IO_IN, 16'h003F, PORT_KEYS, 8'h00, 6'd0));
    send_word(mk(OP_IO_OUT, 16'hFFFF, 3'd3, 8'hFF, 6'd0));
    send_word(mk(OP_MEM_WRITE, 16'h0000, 3'd0, 8'h3C, 6'd0));
    send_word(mk(OP_MEM_READ, 16'h0000, 3'd0, 8'h00, 6'd0));
    send_word(mk(OP_IO_OUT, 16'h0000, PORT_CTRL, 8'hFD, 6'd0));
    send_word(mk(OP_SPARE_A, 16'hFFFF, 3'd7, 8'hFF, 6'd63));
    send_word(mk(OP_SPARE_B, 16'hFFFF, 3'd7, 8'hFF, 6'd63));

    for (int p = 0; p < 4; p++) begin
      write_rom_extended(p % 2 == 1);
      case (p)
        0: begin
          sender_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          sender_idle_pct = 46;
          stall_pct <= 0;
          send_word(mk(OP_ROM_LOAD, 16'h4000, 3'd0, 8'h96, 6'd0));
          send_word(mk(OP_MEM_READ, 16'hC000, 3'd0, 8'h00, 6'd0));
          send_word(mk(OP_MEM_WRITE, 16'hC000, 3'd0, 8'h00, 6'd0));
          send_word(mk(OP_MEM_READ, 16'hC000, 3'd0, 8'h00, 6'd0));
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct <= 46;
        end
        default: begin
          sender_idle_pct = 15;
          stall_pct <= 15;
        end
      endcase
      for (int n = 0; n < 100; n++) begin
        if (p == 2 && n == 30) hold_req <= 1'b1;
        send_word(random_word());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (shadow.mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: sim.f
design/mbd_pkg.sv
design/mbd_ram.sv
design/machine_bus_decoder.sv
design/mbd_chk.sv
sim/machine_bus_decoder_tb.sv
